/* rtl/spob_pkg.sv */
// Shared constants, types and helper functions of the sky patch orientation pipeline.
package spob_pkg;

    localparam int ROOT_W = 30;
    localparam int QUO_W = 15;
    localparam int SQRT_STEPS = ROOT_W;
    localparam int DIV_STEPS = QUO_W;

    localparam logic signed [15:0] Q14_ONE = 16'sd16384;
    localparam logic [30:0] SIN_C9 = 31'd172271;
    localparam logic [3:0][30:0] SIN_COEF = {31'd1686629713, 31'd693598668,
                                            31'd85569306, 31'd5026995};
    localparam logic [59:0] UP_THRESH = 60'd268 << 28;
    localparam logic [30:0] UP_ONE_Q28 = 31'd268435456;

    localparam logic [1:0] QUAD_FIRST = 2'd0;
    localparam logic [1:0] QUAD_SECOND = 2'd1;
    localparam logic [1:0] QUAD_THIRD = 2'd2;

    typedef struct packed {
        logic [31:0]           rem;
        logic [2*ROOT_W-1:0]   rad;
        logic [ROOT_W-1:0]     root;
    } t_sqrt;

    typedef struct packed {
        logic [ROOT_W:0]       rem;
        logic [QUO_W-1:0]      num;
        logic [QUO_W-1:0]      quo;
    } t_div;

    typedef struct packed {
        logic [15:0] radius;
        logic [15:0] tex;
        logic        none;
    } t_pass;

    typedef struct packed {
        logic [1:0]  quad;
        logic [15:0] dx;
        logic [15:0] dy;
        logic [15:0] dz;
        t_pass       pass;
    } t_rot_side;

    typedef struct packed {
        logic [2:0][15:0] t;
        t_pass            pass;
    } t_up_side;

    typedef struct packed {
        logic [2:0][15:0] t;
        logic [2:0][15:0] u;
        t_pass            pass;
    } t_cr_side;

    function automatic logic signed [15:0] f_clamp(input logic signed [33:0] v);
        logic signed [15:0] res;
        if (v > 34'sd16384) begin
            res = Q14_ONE;
        end else if (v < -34'sd16384) begin
            res = -Q14_ONE;
        end else begin
            res = v[15:0];
        end
        return res;
    endfunction

endpackage

/* rtl/spob_sine.sv */
// Pipelined quarter-wave sine polynomial for two phases at once.
module spob_sine #(
    parameter int SIDE_W = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_vld,
    input  logic [1:0][14:0]  i_ph,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_vld,
    output logic [1:0][14:0]  o_sin,
    output logic [SIDE_W-1:0] o_side
);

    logic [7:1]        r_vld;
    logic [SIDE_W-1:0] r_side [1:7];
    logic [1:0][30:0]  r_x [1:5];
    logic [1:0][30:0]  r_x2 [1:4];
    logic [1:0][30:0]  r_s [2:5];
    logic [1:0][30:0]  r_r;
    logic [1:0][14:0]  r_o;

    logic [1:0][30:0]  w_x0;
    logic [1:0][30:0]  n_x2;
    logic [1:0][30:0]  n_s [2:5];
    logic [1:0][30:0]  n_r;
    logic [1:0][14:0]  n_o;
    logic [61:0]       v_prod;
    logic [31:0]       v_rnd;

    always_comb begin
        v_prod = '0;
        v_rnd = '0;
        for (int j = 0; j < 2; j++) begin
            w_x0[j] = {i_ph[j], 16'b0};
            v_prod = 62'(w_x0[j]) * 62'(w_x0[j]);
            n_x2[j] = v_prod[60:30];
            v_prod = 62'(r_x2[1][j]) * 62'(spob_pkg::SIN_C9);
            n_s[2][j] = spob_pkg::SIN_COEF[0] - v_prod[60:30];
            for (int k = 3; k <= 5; k++) begin
                v_prod = 62'(r_x2[k-1][j]) * 62'(r_s[k-1][j]);
                n_s[k][j] = spob_pkg::SIN_COEF[k-2] - v_prod[60:30];
            end
            v_prod = 62'(r_x[5][j]) * 62'(r_s[5][j]);
            n_r[j] = v_prod[60:30];
            v_rnd = 32'(r_r[j]) + 32'd32768;
            n_o[j] = (v_rnd[31:16] > 16'd16384) ? 15'd16384 : v_rnd[30:16];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[6:1], i_vld};
        end
        r_side[1] <= i_side;
        for (int k = 2; k <= 7; k++) begin
            r_side[k] <= r_side[k-1];
        end
        r_x[1] <= w_x0;
        for (int k = 2; k <= 5; k++) begin
            r_x[k] <= r_x[k-1];
            r_s[k] <= n_s[k];
        end
        r_x2[1] <= n_x2;
        for (int k = 2; k <= 4; k++) begin
            r_x2[k] <= r_x2[k-1];
        end
        r_r <= n_r;
        r_o <= n_o;
    end

    assign o_vld = r_vld[7];
    assign o_sin = r_o;
    assign o_side = r_side[7];

endmodule

/* rtl/spob_sqrt_cell.sv */
// One digit step of the integer square root chain.
module spob_sqrt_cell #(
    parameter int SIDE_W = 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_vld,
    input  spob_pkg::t_sqrt    i_st,
    input  logic [SIDE_W-1:0]  i_side,
    output logic               o_vld,
    output spob_pkg::t_sqrt    o_st,
    output logic [SIDE_W-1:0]  o_side
);

    localparam int RW = spob_pkg::ROOT_W;

    logic              r_vld;
    spob_pkg::t_sqrt   r_st;
    logic [SIDE_W-1:0] r_side;
    spob_pkg::t_sqrt   n_st;
    logic [31:0]       w_cur;
    logic [31:0]       w_trial;

    always_comb begin
        w_cur = {i_st.rem[29:0], i_st.rad[2*RW-1 -: 2]};
        w_trial = 32'({i_st.root, 2'b01});
        n_st.rad = {i_st.rad[2*RW-3:0], 2'b00};
        if (w_cur >= w_trial) begin
            n_st.rem = w_cur - w_trial;
            n_st.root = {i_st.root[RW-2:0], 1'b1};
        end else begin
            n_st.rem = w_cur;
            n_st.root = {i_st.root[RW-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_vld;
        end
        r_st <= n_st;
        r_side <= i_side;
    end

    assign o_vld = r_vld;
    assign o_st = r_st;
    assign o_side = r_side;

endmodule

/* rtl/spob_div_cell.sv */
// One quotient bit step for three restoring dividers sharing a divisor.
module spob_div_cell #(
    parameter int SIDE_W = 1
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_vld,
    input  logic [spob_pkg::ROOT_W-1:0] i_len,
    input  spob_pkg::t_div [2:0]        i_st,
    input  logic [SIDE_W-1:0]           i_side,
    output logic                        o_vld,
    output logic [spob_pkg::ROOT_W-1:0] o_len,
    output spob_pkg::t_div [2:0]        o_st,
    output logic [SIDE_W-1:0]           o_side
);

    localparam int RW = spob_pkg::ROOT_W;
    localparam int QW = spob_pkg::QUO_W;

    logic                 r_vld;
    logic [RW-1:0]        r_len;
    spob_pkg::t_div [2:0] r_st;
    logic [SIDE_W-1:0]    r_side;
    spob_pkg::t_div [2:0] n_st;
    logic [2:0][RW:0]     w_cur;
    logic [2:0]           w_bit;

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            w_cur[j] = {i_st[j].rem[RW-1:0], i_st[j].num[QW-1]};
            w_bit[j] = (w_cur[j] >= {1'b0, i_len});
            n_st[j].rem = w_bit[j] ? (w_cur[j] - {1'b0, i_len}) : w_cur[j];
            n_st[j].num = {i_st[j].num[QW-2:0], 1'b0};
            n_st[j].quo = {i_st[j].quo[QW-2:0], w_bit[j]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_vld;
        end
        r_len <= i_len;
        r_st <= n_st;
        r_side <= i_side;
    end

    assign o_vld = r_vld;
    assign o_len = r_len;
    assign o_st = r_st;
    assign o_side = r_side;

endmodule

/* rtl/spob_norm.sv */
// Vector normalizer: squared length, square root chain and divider chain to Q2.14.
module spob_norm #(
    parameter int SIDE_W = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_vld,
    input  logic [2:0][30:0]  i_vec,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_vld,
    output logic [2:0][15:0]  o_vec,
    output logic [SIDE_W-1:0] o_side
);

    localparam int RW = spob_pkg::ROOT_W;
    localparam int QW = spob_pkg::QUO_W;
    localparam int SQ_SIDE_W = 3 * RW + 3 + SIDE_W;
    localparam int DV_SIDE_W = 3 + 1 + SIDE_W;
    localparam int NUM_W = RW + 14;

    logic [2:0][RW-1:0] n1_abs;
    logic [2:0][30:0]   w_mag;

    logic               r1_vld;
    logic [2:0][RW-1:0] r1_abs;
    logic [2:0]         r1_neg;
    logic [SIDE_W-1:0]  r1_side;

    logic                 r2_vld;
    logic [2:0][2*RW-1:0] r2_sq;
    logic [2:0][RW-1:0]   r2_abs;
    logic [2:0]           r2_neg;
    logic [SIDE_W-1:0]    r2_side;

    logic                   r3_vld;
    spob_pkg::t_sqrt        r3_st;
    logic [SQ_SIDE_W-1:0]   r3_side;

    logic                 w_sq_vld  [0:spob_pkg::SQRT_STEPS];
    spob_pkg::t_sqrt      w_sq_st   [0:spob_pkg::SQRT_STEPS];
    logic [SQ_SIDE_W-1:0] w_sq_side [0:spob_pkg::SQRT_STEPS];

    logic [RW-1:0]        w_len;
    logic [2:0][RW-1:0]   w_fabs;
    logic [2:0]           w_fneg;
    logic [SIDE_W-1:0]    w_fside;
    logic [NUM_W-1:0]     v_num;
    spob_pkg::t_div [2:0] n4_dv;

    logic                 r4_vld;
    logic [RW-1:0]        r4_len;
    spob_pkg::t_div [2:0] r4_dv;
    logic [DV_SIDE_W-1:0] r4_side;

    logic                 w_dv_vld  [0:spob_pkg::DIV_STEPS];
    logic [RW-1:0]        w_dv_len  [0:spob_pkg::DIV_STEPS];
    spob_pkg::t_div [2:0] w_dv_st   [0:spob_pkg::DIV_STEPS];
    logic [DV_SIDE_W-1:0] w_dv_side [0:spob_pkg::DIV_STEPS];

    logic [2:0]         w_oneg;
    logic               w_ozero;
    logic [2:0][15:0]   n5_vec;
    logic [15:0]        v_mag;

    logic               r5_vld;
    logic [2:0][15:0]   r5_vec;
    logic [SIDE_W-1:0]  r5_side;

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            w_mag[j] = i_vec[j][30] ? (~i_vec[j] + 31'd1) : i_vec[j];
            n1_abs[j] = w_mag[j][RW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
        end else begin
            r1_vld <= i_vld;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
        end
        r1_abs <= n1_abs;
        for (int j = 0; j < 3; j++) begin
            r1_neg[j] <= i_vec[j][30];
            r2_sq[j] <= (2*RW)'(r1_abs[j]) * (2*RW)'(r1_abs[j]);
        end
        r1_side <= i_side;
        r2_abs <= r1_abs;
        r2_neg <= r1_neg;
        r2_side <= r1_side;
        r3_st.rem <= '0;
        r3_st.root <= '0;
        r3_st.rad <= r2_sq[0] + r2_sq[1] + r2_sq[2];
        r3_side <= {r2_abs, r2_neg, r2_side};
    end

    assign w_sq_vld[0] = r3_vld;
    assign w_sq_st[0] = r3_st;
    assign w_sq_side[0] = r3_side;

    for (genvar g = 0; g < spob_pkg::SQRT_STEPS; g++) begin : g_sqrt
        spob_sqrt_cell #(
            .SIDE_W(SQ_SIDE_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_vld   (w_sq_vld[g]),
            .i_st    (w_sq_st[g]),
            .i_side  (w_sq_side[g]),
            .o_vld   (w_sq_vld[g+1]),
            .o_st    (w_sq_st[g+1]),
            .o_side  (w_sq_side[g+1])
        );
    end

    assign w_len = w_sq_st[spob_pkg::SQRT_STEPS].root;
    assign w_fabs = w_sq_side[spob_pkg::SQRT_STEPS][SQ_SIDE_W-1 -: 3*RW];
    assign w_fneg = w_sq_side[spob_pkg::SQRT_STEPS][SIDE_W+2 -: 3];
    assign w_fside = w_sq_side[spob_pkg::SQRT_STEPS][SIDE_W-1:0];

    always_comb begin
        v_num = '0;
        for (int j = 0; j < 3; j++) begin
            v_num = {w_fabs[j], 14'b0} + NUM_W'(w_len[RW-1:1]);
            n4_dv[j].rem = (RW+1)'(v_num[NUM_W-1:QW]);
            n4_dv[j].num = v_num[QW-1:0];
            n4_dv[j].quo = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
        end else begin
            r4_vld <= w_sq_vld[spob_pkg::SQRT_STEPS];
        end
        r4_len <= w_len;
        r4_dv <= n4_dv;
        r4_side <= {w_fneg, (w_len == '0), w_fside};
    end

    assign w_dv_vld[0] = r4_vld;
    assign w_dv_len[0] = r4_len;
    assign w_dv_st[0] = r4_dv;
    assign w_dv_side[0] = r4_side;

    for (genvar g = 0; g < spob_pkg::DIV_STEPS; g++) begin : g_div
        spob_div_cell #(
            .SIDE_W(DV_SIDE_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_vld   (w_dv_vld[g]),
            .i_len   (w_dv_len[g]),
            .i_st    (w_dv_st[g]),
            .i_side  (w_dv_side[g]),
            .o_vld   (w_dv_vld[g+1]),
            .o_len   (w_dv_len[g+1]),
            .o_st    (w_dv_st[g+1]),
            .o_side  (w_dv_side[g+1])
        );
    end

    assign w_oneg = w_dv_side[spob_pkg::DIV_STEPS][DV_SIDE_W-1 -: 3];
    assign w_ozero = w_dv_side[spob_pkg::DIV_STEPS][SIDE_W];

    always_comb begin
        v_mag = '0;
        for (int j = 0; j < 3; j++) begin
            v_mag = 16'(w_dv_st[spob_pkg::DIV_STEPS][j].quo);
            if (w_ozero) begin
                n5_vec[j] = '0;
            end else if (w_oneg[j]) begin
                n5_vec[j] = ~v_mag + 16'd1;
            end else begin
                n5_vec[j] = v_mag;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_vld <= 1'b0;
        end else begin
            r5_vld <= w_dv_vld[spob_pkg::DIV_STEPS];
        end
        r5_vec <= n5_vec;
        r5_side <= w_dv_side[spob_pkg::DIV_STEPS][SIDE_W-1:0];
    end

    assign o_vld = r5_vld;
    assign o_vec = r5_vec;
    assign o_side = r5_side;

endmodule

/* rtl/sky_patch_orient_basis.sv */
// Sky patch orientation: rotation about the zenith and orthonormal up and right vectors.
// Throughput: one word per cycle; busy is always low since every stage is a register stage.
// Most of the latency lies in the two normalizers, each a 30 cell square root chain and 15 cell divider.
// Reset (synchronous, active low) clears all valid bits, so no result strobe follows reset.
// The receiver cannot stall: o_done marks each result for exactly one cycle.
module sky_patch_orient_basis (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [15:0] i_turn_angle,
    input  logic [15:0] i_dir_x,
    input  logic [15:0] i_dir_y,
    input  logic [15:0] i_dir_z,
    input  logic [15:0] i_angular_radius,
    input  logic [15:0] i_texture_index,
    input  logic        i_texture_present,
    output logic        o_done,
    output logic [15:0] o_out_dir_x,
    output logic [15:0] o_out_dir_y,
    output logic [15:0] o_out_dir_z,
    output logic [15:0] o_right_x,
    output logic [15:0] o_right_y,
    output logic [15:0] o_right_z,
    output logic [15:0] o_up_x,
    output logic [15:0] o_up_y,
    output logic [15:0] o_up_z,
    output logic [15:0] o_out_radius,
    output logic [15:0] o_out_texture,
    output logic        o_drawn
);

    localparam int ROT_W = $bits(spob_pkg::t_rot_side);
    localparam int UP_W = $bits(spob_pkg::t_up_side);
    localparam int CR_W = $bits(spob_pkg::t_cr_side);

    logic                r0_vld;
    logic [15:0]         r0_ang;
    spob_pkg::t_rot_side r0_side;

    logic                w_sn_vld;
    logic [1:0][14:0]    w_sin;
    logic [ROT_W-1:0]    w_sn_bits;
    spob_pkg::t_rot_side w_sn_side;
    logic [1:0][14:0]    w_ph;

    logic signed [15:0]  n1_sn;
    logic signed [15:0]  n1_cs;
    logic signed [15:0]  w_sa;
    logic signed [15:0]  w_sb;

    logic                r1_vld;
    logic signed [15:0]  r1_sn;
    logic signed [15:0]  r1_cs;
    logic signed [15:0]  r1_dx;
    logic signed [15:0]  r1_dy;
    logic signed [15:0]  r1_dz;
    spob_pkg::t_pass     r1_pass;

    logic                r2_vld;
    logic signed [31:0]  r2_pxc;
    logic signed [31:0]  r2_pys;
    logic signed [31:0]  r2_pxs;
    logic signed [31:0]  r2_pyc;
    logic signed [15:0]  r2_dz;
    spob_pkg::t_pass     r2_pass;

    logic signed [33:0]  w_ra;
    logic signed [33:0]  w_rb;
    logic [2:0][15:0]    n3_t;

    logic                r3_vld;
    logic [2:0][15:0]    r3_t;
    spob_pkg::t_pass     r3_pass;

    logic signed [31:0]  w_p0;
    logic signed [31:0]  w_p1;
    logic signed [31:0]  w_p2;
    logic [2:0][30:0]    n4_u;

    logic                r4_vld;
    logic [2:0][30:0]    r4_u;
    logic [2:0][15:0]    r4_t;
    spob_pkg::t_pass     r4_pass;

    logic [2:0][28:0]    w_umag;
    logic [2:0][30:0]    w_uneg;

    logic                r5_vld;
    logic [2:0][57:0]    r5_sq;
    logic [2:0][30:0]    r5_u;
    logic [2:0][15:0]    r5_t;
    spob_pkg::t_pass     r5_pass;

    logic [59:0]         w_l2;
    logic [2:0][30:0]    n6_u;

    logic                r6_vld;
    logic [2:0][30:0]    r6_u;
    spob_pkg::t_up_side  r6_side;

    logic                w_ua_vld;
    logic [2:0][15:0]    w_ua;
    logic [UP_W-1:0]     w_ua_bits;
    spob_pkg::t_up_side  w_ua_side;

    logic                r7_vld;
    logic signed [31:0]  r7_p [0:5];
    logic [2:0][15:0]    r7_u;
    logic [2:0][15:0]    r7_t;
    spob_pkg::t_pass     r7_pass;

    logic signed [31:0]  w_c0;
    logic signed [31:0]  w_c1;
    logic signed [31:0]  w_c2;

    logic                r8_vld;
    logic [2:0][30:0]    r8_c;
    spob_pkg::t_cr_side  r8_side;

    logic                w_rt_vld;
    logic [2:0][15:0]    w_rt;
    logic [CR_W-1:0]     w_rt_bits;
    spob_pkg::t_cr_side  w_rt_side;

    logic                r9_vld;
    logic [2:0][15:0]    r9_dir;
    logic [2:0][15:0]    r9_right;
    logic [2:0][15:0]    r9_up;
    logic [15:0]         r9_radius;
    logic [15:0]         r9_tex;
    logic                r9_drawn;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_vld <= 1'b0;
        end else begin
            r0_vld <= start && !busy;
        end
        r0_ang <= i_turn_angle;
        r0_side.quad <= i_turn_angle[15:14];
        r0_side.dx <= i_dir_x;
        r0_side.dy <= i_dir_y;
        r0_side.dz <= i_dir_z;
        r0_side.pass.radius <= i_angular_radius;
        r0_side.pass.tex <= i_texture_index;
        r0_side.pass.none <= !i_texture_present || (i_angular_radius == 16'd0);
    end

    assign w_ph[0] = {1'b0, r0_ang[13:0]};
    assign w_ph[1] = 15'd16384 - {1'b0, r0_ang[13:0]};

    spob_sine #(
        .SIDE_W(ROT_W)
    ) u_sine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r0_vld),
        .i_ph    (w_ph),
        .i_side  (r0_side),
        .o_vld   (w_sn_vld),
        .o_sin   (w_sin),
        .o_side  (w_sn_bits)
    );

    assign w_sn_side = w_sn_bits;
    assign w_sa = $signed({1'b0, w_sin[0]});
    assign w_sb = $signed({1'b0, w_sin[1]});

    always_comb begin
        case (w_sn_side.quad)
            spob_pkg::QUAD_FIRST: begin
                n1_sn = w_sa;
                n1_cs = w_sb;
            end
            spob_pkg::QUAD_SECOND: begin
                n1_sn = w_sb;
                n1_cs = -w_sa;
            end
            spob_pkg::QUAD_THIRD: begin
                n1_sn = -w_sa;
                n1_cs = -w_sb;
            end
            default: begin
                n1_sn = -w_sb;
                n1_cs = w_sa;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
        end else begin
            r1_vld <= w_sn_vld;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
        end
        r1_sn <= n1_sn;
        r1_cs <= n1_cs;
        r1_dx <= $signed(w_sn_side.dx);
        r1_dy <= $signed(w_sn_side.dy);
        r1_dz <= $signed(w_sn_side.dz);
        r1_pass <= w_sn_side.pass;
        r2_pxc <= r1_dx * r1_cs;
        r2_pys <= r1_dy * r1_sn;
        r2_pxs <= r1_dx * r1_sn;
        r2_pyc <= r1_dy * r1_cs;
        r2_dz <= r1_dz;
        r2_pass <= r1_pass;
        r3_t <= n3_t;
        r3_pass <= r2_pass;
    end

    assign w_ra = (34'(r2_pxc) - 34'(r2_pys) + 34'sd8192) >>> 14;
    assign w_rb = (34'(r2_pxs) + 34'(r2_pyc) + 34'sd8192) >>> 14;
    assign n3_t[0] = spob_pkg::f_clamp(w_ra);
    assign n3_t[1] = spob_pkg::f_clamp(w_rb);
    assign n3_t[2] = spob_pkg::f_clamp(34'(r2_dz));

    assign w_p0 = $signed(r3_t[0]) * $signed(r3_t[2]);
    assign w_p1 = $signed(r3_t[1]) * $signed(r3_t[2]);
    assign w_p2 = $signed(r3_t[2]) * $signed(r3_t[2]);
    assign n4_u[0] = 31'(-w_p0);
    assign n4_u[1] = 31'(-w_p1);
    assign n4_u[2] = spob_pkg::UP_ONE_Q28 - w_p2[30:0];

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            w_uneg[j] = ~r4_u[j] + 31'd1;
            w_umag[j] = r4_u[j][30] ? w_uneg[j][28:0] : r4_u[j][28:0];
        end
    end

    assign w_l2 = 60'(r5_sq[0]) + 60'(r5_sq[1]) + 60'(r5_sq[2]);

    always_comb begin
        if (w_l2 < spob_pkg::UP_THRESH) begin
            n6_u[0] = '0;
            n6_u[1] = spob_pkg::UP_ONE_Q28;
            n6_u[2] = '0;
        end else begin
            n6_u = r5_u;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
            r5_vld <= 1'b0;
            r6_vld <= 1'b0;
        end else begin
            r4_vld <= r3_vld;
            r5_vld <= r4_vld;
            r6_vld <= r5_vld;
        end
        r4_u <= n4_u;
        r4_t <= r3_t;
        r4_pass <= r3_pass;
        for (int j = 0; j < 3; j++) begin
            r5_sq[j] <= 58'(w_umag[j]) * 58'(w_umag[j]);
        end
        r5_u <= r4_u;
        r5_t <= r4_t;
        r5_pass <= r4_pass;
        r6_u <= n6_u;
        r6_side.t <= r5_t;
        r6_side.pass <= r5_pass;
    end

    spob_norm #(
        .SIDE_W(UP_W)
    ) u_norm_up (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r6_vld),
        .i_vec   (r6_u),
        .i_side  (r6_side),
        .o_vld   (w_ua_vld),
        .o_vec   (w_ua),
        .o_side  (w_ua_bits)
    );

    assign w_ua_side = w_ua_bits;

    assign w_c0 = r7_p[0] - r7_p[1];
    assign w_c1 = r7_p[2] - r7_p[3];
    assign w_c2 = r7_p[4] - r7_p[5];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_vld <= 1'b0;
            r8_vld <= 1'b0;
        end else begin
            r7_vld <= w_ua_vld;
            r8_vld <= r7_vld;
        end
        r7_p[0] <= $signed(w_ua[1]) * $signed(w_ua_side.t[2]);
        r7_p[1] <= $signed(w_ua[2]) * $signed(w_ua_side.t[1]);
        r7_p[2] <= $signed(w_ua[2]) * $signed(w_ua_side.t[0]);
        r7_p[3] <= $signed(w_ua[0]) * $signed(w_ua_side.t[2]);
        r7_p[4] <= $signed(w_ua[0]) * $signed(w_ua_side.t[1]);
        r7_p[5] <= $signed(w_ua[1]) * $signed(w_ua_side.t[0]);
        r7_u <= w_ua;
        r7_t <= w_ua_side.t;
        r7_pass <= w_ua_side.pass;
        r8_c[0] <= w_c0[30:0];
        r8_c[1] <= w_c1[30:0];
        r8_c[2] <= w_c2[30:0];
        r8_side.t <= r7_t;
        r8_side.u <= r7_u;
        r8_side.pass <= r7_pass;
    end

    spob_norm #(
        .SIDE_W(CR_W)
    ) u_norm_right (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r8_vld),
        .i_vec   (r8_c),
        .i_side  (r8_side),
        .o_vld   (w_rt_vld),
        .o_vec   (w_rt),
        .o_side  (w_rt_bits)
    );

    assign w_rt_side = w_rt_bits;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r9_vld <= 1'b0;
        end else begin
            r9_vld <= w_rt_vld;
        end
        if (w_rt_side.pass.none) begin
            r9_dir <= {spob_pkg::Q14_ONE, 16'd0, 16'd0};
            r9_right <= {16'd0, 16'd0, spob_pkg::Q14_ONE};
            r9_up <= {16'd0, spob_pkg::Q14_ONE, 16'd0};
            r9_radius <= '0;
            r9_tex <= '0;
            r9_drawn <= 1'b0;
        end else begin
            r9_dir <= w_rt_side.t;
            r9_right <= w_rt;
            r9_up <= w_rt_side.u;
            r9_radius <= w_rt_side.pass.radius;
            r9_tex <= w_rt_side.pass.tex;
            r9_drawn <= 1'b1;
        end
    end

    assign o_done = r9_vld;
    assign o_out_dir_x = r9_dir[0];
    assign o_out_dir_y = r9_dir[1];
    assign o_out_dir_z = r9_dir[2];
    assign o_right_x = r9_right[0];
    assign o_right_y = r9_right[1];
    assign o_right_z = r9_right[2];
    assign o_up_x = r9_up[0];
    assign o_up_y = r9_up[1];
    assign o_up_z = r9_up[2];
    assign o_out_radius = r9_radius;
    assign o_out_texture = r9_tex;
    assign o_drawn = r9_drawn;

endmodule
